// ===== rtl/segment_sweep_convex_brushes_core_macros.svh =====
// Assertion helpers for the segment sweep core.
`ifndef SEGMENT_SWEEP_CONVEX_BRUSHES_CORE_MACROS_SVH
`define SEGMENT_SWEEP_CONVEX_BRUSHES_CORE_MACROS_SVH

// Implication checked every cycle outside reset.
`define SSCB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SSCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sscb_pkg.sv =====
`timescale 1ns / 1ps
package sscb_pkg;
  localparam int CoordWidth = 32;
  localparam int NormalWidth = 16;
  localparam int FractionBits = 16;
  localparam logic [15:0] EpsReset = 16'd7;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_FACE = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DOT1, ST_DOT2, ST_DIV, ST_FACE, ST_CLOSE,
    ST_STOP, ST_STOP_ADD, ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic load_start;
    logic load_end;
    logic load_face;
    logic dot1;
    logic dot2;
    logic div_start;
    logic face_update;
    logic brush_close;
    logic stop_mul;
    logic stop_add;
    logic out_load;
    logic clear_query;
  } ctl_cmd_t;

  typedef struct packed {
    logic face_skip;
    logic need_div;
    logic div_done;
  } dp_status_t;
endpackage

// ===== rtl/sscb_if.sv =====
`timescale 1ns / 1ps
interface sscb_in_if ();
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] plane_offset;
  logic [7:0] material_index;
  logic last_face_of_brush;
  logic last_of_query;
  modport source(output valid, kind, vec_x, vec_y, vec_z, plane_offset, material_index,
                 last_face_of_brush, last_of_query, input ready);
  modport sink(input valid, kind, vec_x, vec_y, vec_z, plane_offset, material_index,
               last_face_of_brush, last_of_query, output ready);
endinterface

interface sscb_out_if ();
  logic valid;
  logic ready;
  logic hit_found;
  logic [16:0] hit_fraction;
  logic signed [15:0] hit_normal_x;
  logic signed [15:0] hit_normal_y;
  logic signed [15:0] hit_normal_z;
  logic [7:0] hit_material;
  logic signed [31:0] stop_x;
  logic signed [31:0] stop_y;
  logic signed [31:0] stop_z;
  modport source(output valid, hit_found, hit_fraction, hit_normal_x, hit_normal_y,
                 hit_normal_z, hit_material, stop_x, stop_y, stop_z, input ready);
  modport sink(input valid, hit_found, hit_fraction, hit_normal_x, hit_normal_y,
               hit_normal_z, hit_material, stop_x, stop_y, stop_z, output ready);
endinterface

interface sscb_cfg_if ();
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== rtl/segment_sweep_convex_brushes_core.sv =====
`timescale 1ns / 1ps
// Segment sweep core: points just load; a face takes two dot products, then a brush
// update, after the restoring divider (one fraction bit per cycle) if it crosses its
// plane. A closing face closes the brush; a query end sets the stop point before the result word.
// Items are handled one at a time; a pending result blocks only the next query end.
// Synchronous active-high rst: epsilon 7, points zero, best hit and brush cleared.
module segment_sweep_convex_brushes_core #(
  parameter int COORD_WIDTH = sscb_pkg::CoordWidth,
  parameter int NORMAL_WIDTH = sscb_pkg::NormalWidth,
  parameter int FRACTION_BITS = sscb_pkg::FractionBits
) (
  input logic clk,
  input logic rst,
  sscb_in_if.sink in_ch,
  sscb_out_if.source out_ch,
  sscb_cfg_if.sink cfg
);
  import sscb_pkg::*;
  ctl_cmd_t cmd;
  dp_status_t status;
  logic [15:0] eps;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) eps <= EpsReset;
    else if (cfg.valid && cfg.ready) eps <= cfg.data;
  end

  sscb_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .kind(in_ch.kind),
    .last_face(in_ch.last_face_of_brush), .last_query(in_ch.last_of_query),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .status(status), .cmd(cmd)
  );

  sscb_datapath #(
    .COORD_WIDTH(COORD_WIDTH), .NORMAL_WIDTH(NORMAL_WIDTH), .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_x(in_ch.vec_x), .in_y(in_ch.vec_y), .in_z(in_ch.vec_z),
    .in_off(in_ch.plane_offset), .in_mat(in_ch.material_index), .eps(eps),
    .o_hit(out_ch.hit_found), .o_frac(out_ch.hit_fraction),
    .o_nx(out_ch.hit_normal_x), .o_ny(out_ch.hit_normal_y), .o_nz(out_ch.hit_normal_z),
    .o_mat(out_ch.hit_material),
    .o_sx(out_ch.stop_x), .o_sy(out_ch.stop_y), .o_sz(out_ch.stop_z)
  );
endmodule

// ===== rtl/sscb_div.sv =====
`timescale 1ns / 1ps
// Restoring fraction divider, one quotient bit per cycle.
module sscb_div #(
  parameter int FRACTION_BITS = 16,
  parameter int DW = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic done,
  output logic [FRACTION_BITS:0] quot
);
  localparam int CW = $clog2(FRACTION_BITS + 1);
  logic [DW:0] rem;
  logic [DW:0] dn;
  logic [FRACTION_BITS:0] q;
  logic [CW-1:0] cnt;
  logic busy;
  logic [DW+1:0] rem2;

  assign rem2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num >= den) begin
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          busy <= 1'b1;
          cnt <= CW'(FRACTION_BITS);
        end
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
      dn <= {1'b0, den};
      q <= (num >= den) ? (FRACTION_BITS + 1)'(1) << FRACTION_BITS : '0;
    end else if (busy) begin
      if (rem2 >= {1'b0, dn}) begin
        rem <= (DW + 1)'(rem2 - {1'b0, dn});
        q <= {q[FRACTION_BITS-1:0], 1'b1};
      end else begin
        rem <= rem2[DW:0];
        q <= {q[FRACTION_BITS-1:0], 1'b0};
      end
    end
  end

  assign quot = q;
endmodule

// ===== rtl/sscb_datapath.sv =====
`timescale 1ns / 1ps
module sscb_datapath #(
  parameter int COORD_WIDTH = sscb_pkg::CoordWidth,
  parameter int NORMAL_WIDTH = sscb_pkg::NormalWidth,
  parameter int FRACTION_BITS = sscb_pkg::FractionBits
) (
  input  logic clk,
  input  logic rst,
  input  sscb_pkg::ctl_cmd_t cmd,
  output sscb_pkg::dp_status_t status,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  input  logic [31:0] in_z,
  input  logic [31:0] in_off,
  input  logic [7:0] in_mat,
  input  logic [15:0] eps,
  output logic o_hit,
  output logic [16:0] o_frac,
  output logic [15:0] o_nx,
  output logic [15:0] o_ny,
  output logic [15:0] o_nz,
  output logic [7:0] o_mat,
  output logic [31:0] o_sx,
  output logic [31:0] o_sy,
  output logic [31:0] o_sz
);
  import sscb_pkg::*;
  localparam int NF = NORMAL_WIDTH - 2;
  localparam int DW = 64;
  localparam int FW = FRACTION_BITS + 1;
  localparam int PW = NORMAL_WIDTH + COORD_WIDTH;
  localparam logic [FW-1:0] FracOne = FW'(1) << FRACTION_BITS;
  localparam logic [NORMAL_WIDTH-1:0] NormOne = NORMAL_WIDTH'(1) << NF;

  logic signed [COORD_WIDTH-1:0] ps [3];
  logic signed [COORD_WIDTH-1:0] pe [3];
  logic signed [NORMAL_WIDTH-1:0] fn [3];
  logic signed [COORD_WIDTH-1:0] foff;
  logic [7:0] fmat;
  logic signed [DW-1:0] d1, d2;
  logic signed [PW-1:0] prod [3];

  logic [FW-1:0] b_enter, b_leave;
  logic signed [NORMAL_WIDTH-1:0] b_n [3];
  logic [7:0] b_mat;
  logic f_out, f_cross, f_rej;
  logic best_hit;
  logic [FW-1:0] best_frac;
  logic signed [NORMAL_WIDTH-1:0] best_n [3];
  logic [7:0] best_mat;

  logic [DW-1:0] m1, m2;
  logic div_done;
  logic [FW-1:0] quot;
  logic signed [DW-1:0] neg_eps;
  logic [DW-1:0] smag [3];
  logic sneg [3];

  sscb_div #(.FRACTION_BITS(FRACTION_BITS), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .num(m1), .den(DW'(m1 + m2)), .done(div_done), .quot(quot)
  );

  assign m1 = d1[DW-1] ? DW'(-d1) : d1;
  assign m2 = d2[DW-1] ? DW'(-d2) : d2;
  assign neg_eps = -(DW'(eps) <<< NF);

  assign status.face_skip = f_rej;
  assign status.need_div = (d1 > 0) != (d2 > 0);
  assign status.div_done = div_done;

  // products for one dot product; registered in d1/d2, one point per cycle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = fn[i] * (cmd.dot1 ? ps[i] : pe[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      ps[0] <= COORD_WIDTH'(in_x); ps[1] <= COORD_WIDTH'(in_y); ps[2] <= COORD_WIDTH'(in_z);
    end
    if (cmd.load_end) begin
      pe[0] <= COORD_WIDTH'(in_x); pe[1] <= COORD_WIDTH'(in_y); pe[2] <= COORD_WIDTH'(in_z);
    end
    if (cmd.load_face) begin
      fn[0] <= NORMAL_WIDTH'(in_x); fn[1] <= NORMAL_WIDTH'(in_y);
      fn[2] <= NORMAL_WIDTH'(in_z);
      foff <= COORD_WIDTH'(in_off);
      fmat <= in_mat;
    end
    if (cmd.dot1) d1 <= DW'(prod[0]) + DW'(prod[1]) + DW'(prod[2]) - (DW'(foff) <<< NF);
    if (cmd.dot2) d2 <= DW'(prod[0]) + DW'(prod[1]) + DW'(prod[2]) - (DW'(foff) <<< NF);
    if (rst) begin
      ps[0] <= '0; ps[1] <= '0; ps[2] <= '0;
      pe[0] <= '0; pe[1] <= '0; pe[2] <= '0;
    end
  end

  // brush and best-hit state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_query || cmd.brush_close) begin
      b_enter <= '0; b_leave <= FracOne;
      b_n[0] <= '0; b_n[1] <= NormOne; b_n[2] <= '0;
      b_mat <= '0; f_out <= 1'b0; f_cross <= 1'b0; f_rej <= 1'b0;
    end else if (cmd.face_update && !f_rej) begin
      if (d1 > neg_eps) f_out <= 1'b1;
      if (d1 > 0 && d2 > 0) begin
        f_rej <= 1'b1;
      end else if (status.need_div) begin
        if (d1 > 0) begin
          if (quot > b_enter) begin
            b_enter <= quot; b_n[0] <= fn[0]; b_n[1] <= fn[1]; b_n[2] <= fn[2];
            b_mat <= fmat; f_cross <= 1'b1;
          end
        end else if (quot < b_leave) begin
          b_leave <= quot;
        end
      end
    end
    if (rst || cmd.clear_query) begin
      best_hit <= 1'b0; best_frac <= FracOne;
      best_n[0] <= '0; best_n[1] <= NormOne; best_n[2] <= '0; best_mat <= '0;
    end else if (cmd.brush_close && !f_rej && f_out && f_cross && b_enter <= b_leave &&
                 b_enter < FracOne && b_enter < best_frac) begin
      best_hit <= 1'b1; best_frac <= b_enter;
      best_n[0] <= b_n[0]; best_n[1] <= b_n[1]; best_n[2] <= b_n[2]; best_mat <= b_mat;
    end
  end

  function automatic logic [31:0] sadd(input int i);
    logic [DW-1:0] s;
    s = DW'(ps[i]);
    if (sneg[i]) s = s - ((smag[i] + DW'(FracOne - 1'b1)) >> FRACTION_BITS);
    else s = s + (smag[i] >> FRACTION_BITS);
    return s[31:0];
  endfunction

  // stop point: magnitude product registered, then round and add
  always_ff @(posedge clk) begin
    if (cmd.stop_mul) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [COORD_WIDTH:0] dl;
        logic [COORD_WIDTH:0] dm;
        logic [COORD_WIDTH+FW:0] sp;
        dl = (COORD_WIDTH + 1)'(pe[i]) - (COORD_WIDTH + 1)'(ps[i]);
        dm = dl[COORD_WIDTH] ? (COORD_WIDTH + 1)'(-dl) : (COORD_WIDTH + 1)'(dl);
        sp = dm * best_frac;
        sneg[i] <= dl[COORD_WIDTH];
        smag[i] <= DW'(sp);
      end
    end
    if (cmd.out_load) begin
      o_hit <= best_hit; o_frac <= 17'(best_frac);
      o_nx <= 16'(best_n[0]); o_ny <= 16'(best_n[1]); o_nz <= 16'(best_n[2]);
      o_mat <= best_mat;
    end
    if (cmd.stop_add) begin
      o_sx <= sadd(0); o_sy <= sadd(1); o_sz <= sadd(2);
    end
  end
endmodule

// ===== rtl/sscb_ctrl.sv =====
`timescale 1ns / 1ps
`include "segment_sweep_convex_brushes_core_macros.svh"
module sscb_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] kind,
  input  logic last_face,
  input  logic last_query,
  input  logic out_ready,
  output logic out_valid,
  input  sscb_pkg::dp_status_t status,
  output sscb_pkg::ctl_cmd_t cmd
);
  import sscb_pkg::*;
  ctl_state_t state, state_next;
  logic close_req, query_req, close_next, query_next;
  logic out_pending, out_set;
  logic acc;

  assign acc = in_valid && in_ready;
  assign out_valid = out_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; close_req <= 1'b0; query_req <= 1'b0; out_pending <= 1'b0;
    end else begin
      state <= state_next; close_req <= close_next; query_req <= query_next;
      if (out_set) out_pending <= 1'b1;
      else if (out_pending && out_ready) out_pending <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    close_next = close_req;
    query_next = query_req;
    out_set = 1'b0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (acc) begin
          close_next = last_face || last_query;
          query_next = last_query;
          unique case (kind)
            KIND_START: begin
              cmd.load_start = 1'b1;
              if (last_query) state_next = ST_STOP;
            end
            KIND_END: begin
              cmd.load_end = 1'b1;
              if (last_query) state_next = ST_STOP;
            end
            KIND_FACE: begin
              cmd.load_face = 1'b1;
              state_next = ST_DOT1;
            end
            default: begin
              close_next = 1'b0;
              query_next = 1'b0;
            end
          endcase
        end
      end
      ST_DOT1: begin
        cmd.dot1 = 1'b1;
        state_next = ST_DOT2;
      end
      ST_DOT2: begin
        cmd.dot2 = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!status.face_skip && status.need_div) begin
          cmd.div_start = 1'b1;
          state_next = ST_FACE;
        end else begin
          cmd.face_update = 1'b1;
          state_next = close_req ? ST_CLOSE : ST_IDLE;
        end
      end
      ST_FACE: begin
        if (status.div_done) begin
          cmd.face_update = 1'b1;
          state_next = close_req ? ST_CLOSE : ST_IDLE;
        end
      end
      ST_CLOSE: begin
        cmd.brush_close = 1'b1;
        state_next = query_req ? ST_STOP : ST_IDLE;
      end
      ST_STOP: begin
        if (!out_pending) begin
          cmd.stop_mul = 1'b1;
          state_next = ST_STOP_ADD;
        end
      end
      ST_STOP_ADD: begin
        cmd.stop_add = 1'b1;
        cmd.out_load = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_set = 1'b1;
        cmd.clear_query = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `SSCB_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == ST_IDLE, "ready outside idle")
  `SSCB_ASSERT_NEXT(a_out_set, clk, rst, out_set, out_valid, "result not raised")
  `SSCB_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load, !out_pending, "result overwritten")
  `SSCB_ASSERT_NEXT(a_face_dot, clk, rst, cmd.load_face, state == ST_DOT1, "face skipped dot")
endmodule
